/* rtl/core/nht_pkg.sv */
// ----------------------------------------------------------------------------
// nht_pkg
// Types and constants shared by the node heartbeat table.
// ----------------------------------------------------------------------------
`default_nettype none

package nht_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_RECOGNITION_CODE  = 3'd0;
  localparam logic [2:0] CFG_SENSOR_EVENT_CODE = 3'd1;
  localparam logic [2:0] CFG_SAFETY_EVENT_CODE = 3'd2;
  localparam logic [2:0] CFG_WATCHED_NODE_ID   = 3'd3;
  localparam logic [2:0] CFG_HEARTBEAT_TIMEOUT = 3'd4;
  localparam logic [2:0] CFG_MAPPING_WAIT      = 3'd5;
  localparam logic [2:0] CFG_IGNORE_DEAD_NODES = 3'd6;

  // Register values after reset
  localparam logic [15:0] RST_RECOGNITION_CODE  = 16'd1;
  localparam logic [15:0] RST_SENSOR_EVENT_CODE = 16'd2;
  localparam logic [15:0] RST_SAFETY_EVENT_CODE = 16'd3;
  localparam logic [2:0]  RST_WATCHED_NODE_ID   = 3'd1;
  localparam logic [31:0] RST_HEARTBEAT_TIMEOUT = 32'd3000;
  localparam logic [31:0] RST_MAPPING_WAIT      = 32'd5000;

  // Input item kinds (in_tuser)
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // One node table entry
  typedef struct packed {
    logic [31:0] last_seen;
    logic        alive;
    logic [2:0]  ident;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/core/node_heartbeat_table.sv */
// ----------------------------------------------------------------------------
// node_heartbeat_table
// Liveness monitor for nodes on a frame bus, node table held in one RAM.
// ----------------------------------------------------------------------------
// Each input word is a received frame (in_tuser 0) or one time tick
// (in_tuser 1) and gives exactly one result word. An item is accepted, then
// each entry of the node table is read in turn through the single read port
// of the node RAM (reads are pipelined with the write-back of the entry
// before), and last a new node is appended and the result register loaded.
// The next item is accepted while the result still waits on out_tready. The
// node RAM needs no clearing after reset: only entries below the fill count
// are ever evaluated.
// ----------------------------------------------------------------------------
`default_nettype none

module node_heartbeat_table #(
  parameter int MAX_NODES         = 8,
  parameter int ACTION_FLAG_BIT   = 1,
  parameter int RESPONSE_FLAG_BIT = 0
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: frame_id[10:0], byte_zero[18:11], byte_one[26:19], byte_two[34:27]
  input  wire logic [nht_pkg::IN_DATA_W-1:0] in_tdata,
  // tuser: op
  input  wire logic        in_tuser,
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: person_present[0], safety_byte[8:1], watched_alive[9],
  //        dead_error[10], node_count[14:11], table_overflow[15]
  output logic [nht_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_NODES);

  // configuration registers
  logic [15:0] recog_code_r;
  logic [15:0] sensor_code_r;
  logic [15:0] safety_code_r;
  logic [2:0]  watched_id_r;
  logic [31:0] hb_timeout_r;
  logic [31:0] map_wait_r;
  logic        ignore_dead_r;

  // block state
  nht_pkg::state_t state_r, state_nxt;
  logic [31:0]   tick_r, tick_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic          person_r, person_nxt;
  logic [7:0]    safety_r, safety_nxt;

  // per-item working registers
  logic          op_r, op_nxt;
  logic          resp_r, resp_nxt;
  logic [2:0]    sender_r, sender_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          pend_r, pend_nxt;
  logic [IW-1:0] ev_idx_r, ev_idx_nxt;
  logic          found_r, found_nxt;
  logic          wfound_r, wfound_nxt;
  logic          walive_r, walive_nxt;
  logic          err_r, err_nxt;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic [nht_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // node RAM
  nht_pkg::entry_t mem [0:MAX_NODES-1];
  nht_pkg::entry_t rdata_r;
  nht_pkg::entry_t mem_wd;
  logic            mem_we;
  logic [IW-1:0]   mem_wa;
  logic [IW-1:0]   mem_ra;

  // input fields
  logic [10:0] in_fid;
  logic [15:0] in_code;
  logic [7:0]  in_val;
  logic        in_acc;

  // scan and finish terms
  logic          issue;
  logic          stale;
  logic          hit;
  logic          alive_new;
  logic          append;
  logic          overflow;
  logic          err_fin;
  logic          walive_fin;
  logic [CW-1:0] used_fin;

  assign in_fid   = in_tdata[10:0];
  assign in_code  = {in_tdata[18:11], in_tdata[26:19]};
  assign in_val   = in_tdata[34:27];
  assign in_acc   = in_tvalid && in_tready;

  assign in_tready  = (state_r == nht_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recog_code_r  <= nht_pkg::RST_RECOGNITION_CODE;
      sensor_code_r <= nht_pkg::RST_SENSOR_EVENT_CODE;
      safety_code_r <= nht_pkg::RST_SAFETY_EVENT_CODE;
      watched_id_r  <= nht_pkg::RST_WATCHED_NODE_ID;
      hb_timeout_r  <= nht_pkg::RST_HEARTBEAT_TIMEOUT;
      map_wait_r    <= nht_pkg::RST_MAPPING_WAIT;
      ignore_dead_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nht_pkg::CFG_RECOGNITION_CODE:  recog_code_r  <= cfg_data[15:0];
        nht_pkg::CFG_SENSOR_EVENT_CODE: sensor_code_r <= cfg_data[15:0];
        nht_pkg::CFG_SAFETY_EVENT_CODE: safety_code_r <= cfg_data[15:0];
        nht_pkg::CFG_WATCHED_NODE_ID:   watched_id_r  <= cfg_data[2:0];
        nht_pkg::CFG_HEARTBEAT_TIMEOUT: hb_timeout_r  <= cfg_data;
        nht_pkg::CFG_MAPPING_WAIT:      map_wait_r    <= cfg_data;
        nht_pkg::CFG_IGNORE_DEAD_NODES: ignore_dead_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // node RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  assign mem_ra = rd_idx_r[IW-1:0];
  assign issue  = (rd_idx_r < used_r);

  // evaluate the entry read in the previous cycle
  assign stale     = ((tick_r - rdata_r.last_seen) > hb_timeout_r);
  assign hit       = resp_r && !found_r && (rdata_r.ident == sender_r);
  assign alive_new = op_r ? (rdata_r.alive && !stale) : (rdata_r.alive || hit);

  // finishing step
  assign append     = resp_r && !found_r && (used_r < FULL_COUNT);
  assign overflow   = resp_r && !found_r && (used_r >= FULL_COUNT);
  assign used_fin   = append ? (used_r + CW'(1)) : used_r;
  assign err_fin    = err_r || (op_r && (used_r == '0) && (tick_r > map_wait_r));
  assign walive_fin = wfound_r ? walive_r : (append && (sender_r == watched_id_r));

  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    used_nxt      = used_r;
    person_nxt    = person_r;
    safety_nxt    = safety_r;
    op_nxt        = op_r;
    resp_nxt      = resp_r;
    sender_nxt    = sender_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = pend_r;
    ev_idx_nxt    = ev_idx_r;
    found_nxt     = found_r;
    wfound_nxt    = wfound_r;
    walive_nxt    = walive_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = ev_idx_r;
    mem_wd        = rdata_r;

    // drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      nht_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_tuser;
          sender_nxt = in_fid[10:8];
          resp_nxt   = (in_tuser == nht_pkg::OP_FRAME) && in_fid[ACTION_FLAG_BIT] &&
                       in_fid[RESPONSE_FLAG_BIT] && (in_code == recog_code_r);
          rd_idx_nxt = '0;
          pend_nxt   = 1'b0;
          found_nxt  = 1'b0;
          wfound_nxt = 1'b0;
          walive_nxt = 1'b0;
          err_nxt    = 1'b0;
          if (in_tuser == nht_pkg::OP_TICK) begin
            tick_nxt = tick_r + 32'd1;
          end else if (!in_fid[ACTION_FLAG_BIT]) begin
            if (in_code == sensor_code_r) begin
              person_nxt = (in_val != 8'd0);
            end else if (in_code == safety_code_r) begin
              safety_nxt = in_val;
            end
          end
          state_nxt = nht_pkg::ST_SCAN;
        end
      end

      nht_pkg::ST_SCAN: begin
        if (pend_r) begin
          if (op_r) begin
            if (stale) begin
              mem_we = 1'b1;
              mem_wd.alive = 1'b0;
              if (!ignore_dead_r) begin
                err_nxt = 1'b1;
              end
            end
          end else if (hit) begin
            mem_we = 1'b1;
            mem_wd.alive = 1'b1;
            mem_wd.last_seen = tick_r;
            found_nxt = 1'b1;
          end
          if (!wfound_r && (rdata_r.ident == watched_id_r)) begin
            wfound_nxt = 1'b1;
            walive_nxt = alive_new;
          end
        end
        // advance the read pointer; the last entry is evaluated on the way out
        pend_nxt   = issue;
        ev_idx_nxt = rd_idx_r[IW-1:0];
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
        end else begin
          state_nxt = nht_pkg::ST_DONE;
        end
      end

      nht_pkg::ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_tready) begin
          if (append) begin
            mem_we = 1'b1;
            mem_wa = used_r[IW-1:0];
            mem_wd.ident = sender_r;
            mem_wd.alive = 1'b1;
            mem_wd.last_seen = tick_r;
          end
          used_nxt      = used_fin;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {overflow, 4'(used_fin), err_fin, walive_fin, safety_r, person_r};
          state_nxt     = nht_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = nht_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nht_pkg::ST_IDLE;
      tick_r      <= '0;
      used_r      <= '0;
      person_r    <= 1'b0;
      safety_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      used_r      <= used_nxt;
      person_r    <= person_nxt;
      safety_r    <= safety_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    resp_r     <= resp_nxt;
    sender_r   <= sender_nxt;
    rd_idx_r   <= rd_idx_nxt;
    ev_idx_r   <= ev_idx_nxt;
    found_r    <= found_nxt;
    wfound_r   <= wfound_nxt;
    walive_r   <= walive_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

/* tb/sv/tb_node_heartbeat_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_node_heartbeat_table
// Self-checking testbench for the node heartbeat table.
// ----------------------------------------------------------------------------
// A built-in model of the node table, the tick counter and the stored event
// values predicts one status word per accepted input word. A checker compares
// every status word field by field with the oldest prediction. Directed tests
// cover the reset settings, the empty-table error, recognition responses,
// stale nodes and event codes. Random traffic then runs under several register
// settings, with random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------

module tb_node_heartbeat_table;

  localparam int TABLE_DEPTH   = 8;
  localparam int ACTION_BIT    = 1;
  localparam int RESPONSE_BIT  = 0;
  localparam int MAX_GAP       = 13;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;

  // status word layout, lowest bit last
  typedef struct packed {
    logic       table_overflow;
    logic [3:0] node_count;
    logic       dead_error;
    logic       watched_alive;
    logic [7:0] safety_byte;
    logic       person_present;
  } status_word_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [2:0]                     cfg_index = nht_pkg::CFG_RECOGNITION_CODE;
  logic [31:0]                    cfg_data = '0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [nht_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           in_tuser = nht_pkg::OP_FRAME;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [nht_pkg::OUT_DATA_W-1:0] out_tdata;

  // register copies
  logic [15:0] recog_code  = nht_pkg::RST_RECOGNITION_CODE;
  logic [15:0] sensor_code = nht_pkg::RST_SENSOR_EVENT_CODE;
  logic [15:0] safety_code = nht_pkg::RST_SAFETY_EVENT_CODE;
  logic [2:0]  watch_id    = nht_pkg::RST_WATCHED_NODE_ID;
  logic [31:0] beat_limit  = nht_pkg::RST_HEARTBEAT_TIMEOUT;
  logic [31:0] map_wait    = nht_pkg::RST_MAPPING_WAIT;
  logic        ignore_dead = 1'b0;

  // node table model
  logic [31:0] ticks_now = '0;
  logic [2:0]  node_tag   [TABLE_DEPTH];
  logic        node_up    [TABLE_DEPTH];
  logic [31:0] node_stamp [TABLE_DEPTH];
  int          nodes_held = 0;
  logic        person_flag = 1'b0;
  logic [7:0]  safety_val = '0;

  status_word_t status_q[$];
  status_word_t got_word, want_word;
  int  fail_count = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  int  sender_span = 3;

  node_heartbeat_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Advance the table model by one word and return the status it reports.
  function automatic status_word_t advance_table(logic op, logic [10:0] fid,
                                                 logic [15:0] code, logic [7:0] val);
    status_word_t w;
    logic [31:0]  age;
    bit           found;
    w = '0;
    found = 1'b0;
    if (op == nht_pkg::OP_TICK) begin
      ticks_now = ticks_now + 32'd1;
      for (int i = 0; i < nodes_held; i++) begin
        age = ticks_now - node_stamp[i];
        if (age > beat_limit) begin
          node_up[i] = 1'b0;
          if (!ignore_dead) w.dead_error = 1'b1;
        end
      end
      if (nodes_held == 0 && ticks_now > map_wait) w.dead_error = 1'b1;
    end else if (fid[ACTION_BIT]) begin
      if (fid[RESPONSE_BIT] && code == recog_code) begin
        for (int i = 0; i < nodes_held; i++) begin
          if (!found && node_tag[i] == fid[10:8]) begin
            node_up[i] = 1'b1;
            node_stamp[i] = ticks_now;
            found = 1'b1;
          end
        end
        if (!found) begin
          if (nodes_held >= TABLE_DEPTH) begin
            w.table_overflow = 1'b1;
          end else begin
            node_tag[nodes_held] = fid[10:8];
            node_up[nodes_held] = 1'b1;
            node_stamp[nodes_held] = ticks_now;
            nodes_held++;
          end
        end
      end
    end else if (code == sensor_code) begin
      person_flag = (val != 8'd0);
    end else if (code == safety_code) begin
      safety_val = val;
    end
    found = 1'b0;
    for (int i = 0; i < nodes_held; i++) begin
      if (!found && node_tag[i] == watch_id) begin
        w.watched_alive = node_up[i];
        found = 1'b1;
      end
    end
    w.person_present = person_flag;
    w.safety_byte = safety_val;
    w.node_count = 4'(nodes_held);
    return w;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic logic [10:0] frame_id(logic [2:0] sender, bit action, bit response,
                                           logic [5:0] filler);
    logic [10:0] fid;
    fid = {sender, filler, 2'b00};
    fid[ACTION_BIT] = action;
    fid[RESPONSE_BIT] = response;
    return fid;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_word = out_tdata;
        if (status_q.size() == 0) begin
          $error("status word %h with nothing pending", out_tdata);
          fail_count++;
        end else begin
          want_word = status_q.pop_front();
          check_field("person_present", want_word.person_present, got_word.person_present);
          check_field("safety_byte", want_word.safety_byte, got_word.safety_byte);
          check_field("watched_alive", want_word.watched_alive, got_word.watched_alive);
          check_field("dead_error", want_word.dead_error, got_word.dead_error);
          check_field("node_count", want_word.node_count, got_word.node_count);
          check_field("table_overflow", want_word.table_overflow, got_word.table_overflow);
        end
      end
      if (in_tvalid && in_tready)
        status_q.push_back(advance_table(in_tuser, in_tdata[10:0],
                                         {in_tdata[18:11], in_tdata[26:19]},
                                         in_tdata[34:27]));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nht_pkg::CFG_RECOGNITION_CODE:  recog_code  = cfg_data[15:0];
          nht_pkg::CFG_SENSOR_EVENT_CODE: sensor_code = cfg_data[15:0];
          nht_pkg::CFG_SAFETY_EVENT_CODE: safety_code = cfg_data[15:0];
          nht_pkg::CFG_WATCHED_NODE_ID:   watch_id    = cfg_data[2:0];
          nht_pkg::CFG_HEARTBEAT_TIMEOUT: beat_limit  = cfg_data;
          nht_pkg::CFG_MAPPING_WAIT:      map_wait    = cfg_data;
          nht_pkg::CFG_IGNORE_DEAD_NODES: ignore_dead = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Result sink: random stall before each word, one long hold-off on request.
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Call at a falling edge; returns at the falling edge after the handshake.
  task automatic send_item(input logic op, input logic [10:0] fid,
                           input logic [15:0] code, input logic [7:0] val);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser = op;
    in_tdata = {5'b0, val, code[7:0], code[15:8], fid};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_item(nht_pkg::OP_TICK, 11'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // Drop valid and let every pending status word come back.
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_settings(input logic [15:0] rc, input logic [15:0] sc,
                                input logic [15:0] fc, input logic [2:0] wid,
                                input logic [31:0] limit, input logic [31:0] wait_ticks,
                                input logic ign);
    write_reg(nht_pkg::CFG_RECOGNITION_CODE, {16'd0, rc});
    write_reg(nht_pkg::CFG_SENSOR_EVENT_CODE, {16'd0, sc});
    write_reg(nht_pkg::CFG_SAFETY_EVENT_CODE, {16'd0, fc});
    write_reg(nht_pkg::CFG_WATCHED_NODE_ID, {29'd0, wid});
    write_reg(nht_pkg::CFG_HEARTBEAT_TIMEOUT, limit);
    write_reg(nht_pkg::CFG_MAPPING_WAIT, wait_ticks);
    write_reg(nht_pkg::CFG_IGNORE_DEAD_NODES, {31'd0, ign});
  endtask

  // Mostly ticks and well-formed responses and events, some noise.
  task automatic send_random_item();
    int          pick;
    logic [10:0] fid;
    logic [15:0] code;
    logic [7:0]  val;
    pick = $urandom_range(0, 99);
    fid = 11'($urandom);
    code = 16'($urandom);
    val = 8'($urandom);
    if (pick < 40) begin
      send_item(nht_pkg::OP_TICK, fid, code, val);
    end else if (pick < 72) begin
      fid = frame_id(3'($urandom_range(0, sender_span)), 1'b1, 1'b1, fid[7:2]);
      send_item(nht_pkg::OP_FRAME, fid, recog_code, val);
    end else if (pick < 80) begin
      fid[ACTION_BIT] = 1'b1;
      send_item(nht_pkg::OP_FRAME, fid, code, val);
    end else if (pick < 92) begin
      fid[ACTION_BIT] = 1'b0;
      code = (pick < 86) ? sensor_code : safety_code;
      if ($urandom_range(0, 3) == 0) val = 8'd0;
      send_item(nht_pkg::OP_FRAME, fid, code, val);
    end else begin
      send_item(1'($urandom), fid, code, val);
    end
  endtask

  task automatic test_reset_values();
    send_item(nht_pkg::OP_FRAME, 11'h7FC, nht_pkg::RST_SENSOR_EVENT_CODE, 8'h80);
    send_item(nht_pkg::OP_FRAME, 11'h000, nht_pkg::RST_SENSOR_EVENT_CODE, 8'h00);
    send_item(nht_pkg::OP_FRAME, frame_id(3'd2, 1'b0, 1'b1, 6'h15),
              nht_pkg::RST_SAFETY_EVENT_CODE, 8'hFF);
    send_tick();
  endtask

  // No node mapped yet: error once the time passes the mapping wait.
  task automatic test_empty_table();
    wait_idle();
    write_reg(nht_pkg::CFG_MAPPING_WAIT, 32'd1);
    send_tick();
    send_tick();
    wait_idle();
    write_reg(nht_pkg::CFG_MAPPING_WAIT, 32'hFFFF_FFFF);
    send_tick();
    wait_idle();
    write_reg(nht_pkg::CFG_MAPPING_WAIT, 32'd0);
    send_tick();
  endtask

  task automatic test_recognition();
    wait_idle();
    apply_settings(16'hFFFF, nht_pkg::RST_SENSOR_EVENT_CODE,
                   nht_pkg::RST_SAFETY_EVENT_CODE, 3'd7,
                   32'd2, 32'hFFFF_FFFF, 1'b0);
    send_item(nht_pkg::OP_FRAME, frame_id(3'd7, 1'b1, 1'b1, 6'h00), 16'hFFFF, 8'h00);
    // request, not a response: ignore
    send_item(nht_pkg::OP_FRAME, frame_id(3'd6, 1'b1, 1'b0, 6'h3F), 16'hFFFF, 8'hFF);
    send_item(nht_pkg::OP_FRAME, frame_id(3'd5, 1'b1, 1'b1, 6'h15), 16'hFFFE, 8'h00);
    send_item(nht_pkg::OP_FRAME, frame_id(3'd0, 1'b1, 1'b1, 6'h3F), 16'hFFFF, 8'h55);
    send_item(nht_pkg::OP_FRAME, frame_id(3'd3, 1'b1, 1'b1, 6'h2A), 16'hFFFF, 8'hAA);
    send_item(nht_pkg::OP_FRAME, frame_id(3'd7, 1'b1, 1'b1, 6'h3F), 16'hFFFF, 8'h00);
  endtask

  task automatic test_stale_nodes();
    // third tick after the last response exceeds a timeout of two
    repeat (3) send_tick();
    wait_idle();
    write_reg(nht_pkg::CFG_IGNORE_DEAD_NODES, 32'd1);
    send_tick();
    send_item(nht_pkg::OP_FRAME, frame_id(3'd7, 1'b1, 1'b1, 6'h0F), 16'hFFFF, 8'h00);
    wait_idle();
    write_reg(nht_pkg::CFG_HEARTBEAT_TIMEOUT, 32'd0);
    write_reg(nht_pkg::CFG_IGNORE_DEAD_NODES, 32'd0);
    send_tick();
  endtask

  task automatic test_event_codes();
    wait_idle();
    write_reg(nht_pkg::CFG_SENSOR_EVENT_CODE, 32'h1234);
    write_reg(nht_pkg::CFG_SAFETY_EVENT_CODE, 32'h1234);
    send_item(nht_pkg::OP_FRAME, frame_id(3'd4, 1'b0, 1'b0, 6'h00), 16'h1234, 8'h05);
    wait_idle();
    write_reg(nht_pkg::CFG_SENSOR_EVENT_CODE, 32'hABCD);
    send_item(nht_pkg::OP_FRAME, frame_id(3'd1, 1'b0, 1'b1, 6'h3F), 16'h1234, 8'h7F);
  endtask

  task automatic test_random_traffic();
    logic [15:0] sc;
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      if (phase == 0) begin
        apply_settings(16'h0000, 16'hFFFF, 16'hFFFF, 3'd0, 32'd0, 32'd0, 1'b0);
      end else if (phase == 1) begin
        apply_settings(16'hFFFF, 16'h0000, 16'h0001, 3'd7, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 1'b1);
      end else begin
        sc = 16'($urandom);
        apply_settings(16'($urandom), sc,
                       ($urandom_range(0, 3) == 0) ? sc : 16'($urandom),
                       3'($urandom), 32'($urandom_range(0, 15)), 32'($urandom),
                       1'($urandom));
      end
      quiet = (phase == 2 || phase == 5);
      sender_span = (phase < 3) ? 3 : 7;
      repeat (100) send_random_item();
      quiet = 1'b0;
    end
  endtask

  // Long output stall while input keeps coming: the block must back up.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (30) send_random_item();
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_values();
    test_empty_table();
    test_recognition();
    test_stale_nodes();
    test_event_codes();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
